[rtl/core/sorted_list_insert_core_assert.svh]
// Assertion macros used by the port checker of the sorted list core.
`ifndef SORTED_LIST_INSERT_CORE_ASSERT_SVH
`define SORTED_LIST_INSERT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLIC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list core: assertion failed");

`endif

[rtl/core/slic_pkg.sv]
// Package with the types and constants of the sorted list core.
`default_nettype none
package slic_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int DEFAULT_DEPTH = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DUMP   = 2'd2,
    FUNC_IGNORE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ELEM  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     sorted;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage
`default_nettype wire

[rtl/core/slic_item_if.sv]
// Interface of the input channel of the sorted list core.
`default_nettype none
interface slic_item_if
  import slic_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, output func, output new_value, input ready);
  modport sink (input valid, input func, input new_value, output ready);
endinterface
`default_nettype wire

[rtl/core/slic_result_if.sv]
// Interface of the result channel of the sorted list core.
`default_nettype none
interface slic_result_if
  import slic_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink (input valid, input out_value, input status, input last, output ready);
endinterface
`default_nettype wire

[rtl/core/slic_cell.sv]
// One storage cell of the list chain: compare, shift on insert, rotate on dump.
`default_nettype none
module slic_cell
  import slic_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int INDEX = 0
) (
  input  wire                                 clk,
  input  wire cell_ctrl_t                     ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]     count,
  input  wire logic signed [DATA_W-1:0]       new_value,
  input  wire logic signed [DATA_W-1:0]       head_value,
  input  wire logic signed [DATA_W-1:0]       prev_value,
  input  wire logic signed [DATA_W-1:0]       next_value,
  input  wire logic                           seen_in,
  output logic signed [DATA_W-1:0]            value,
  output logic                                seen_out
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic occupied;
  logic hit;

  // On a sorted insert, a cell is a candidate slot when it holds a value not below
  // the new one, and the slot just past the tail always is one.
  assign occupied = IDX < count;
  assign hit      = (ctrl.sorted && occupied && (value >= new_value)) || (IDX == count);
  assign seen_out = seen_in || hit;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (seen_in) begin
          value <= prev_value;
        end else if (hit) begin
          value <= new_value;
        end
      end
      CELL_ROTATE: begin
        if (IDX == count - CW'(1)) begin
          value <= head_value;
        end else begin
          value <= next_value;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/sorted_list_insert_core.sv]
// Top level of the sorted list core: control, result register and cell chain.
// The list lives in a chain of DEPTH cells, one value per cell, with a single
// fill count beside it. On a sorted insert every cell compares its value with
// the new one at once (an append only picks the slot past the tail), a
// found-first signal ripples down the chain, and in the same edge the cells
// after the insertion point take their left neighbor's value while the chosen
// cell takes the new one. Such items are accepted back to back as long as the
// result register drains. A dump of n elements first enters the dump state;
// then the chain rotates by one position per result transfer, so cell 0 always
// presents the next element and after n steps the list is back in its original
// order. While a dump runs no new item is accepted. The clock rate is set by
// the ripple through the chain, which grows with DEPTH. Results leave through
// an output register, and an item is accepted only when that register is empty
// or its result transfers in the same cycle. A full list drops the value and
// reports it; func 3 is ignored and gives no result. The list contents have no
// reset.
`default_nettype none
module sorted_list_insert_core
  import slic_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire            clk,
  input  wire            rst,
  slic_item_if.sink      item,
  slic_result_if.source  result
);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            left, left_next;
  logic                     res_valid;
  logic signed [DATA_W-1:0] res_value;
  status_t                  res_status;
  logic                     res_last;

  cell_ctrl_t               ctrl;
  logic                     load;
  logic signed [DATA_W-1:0] ld_value;
  status_t                  ld_status;
  logic                     ld_last;
  logic                     out_free;
  logic                     item_xfer;
  logic                     full;

  logic signed [DATA_W-1:0] values [DEPTH];
  logic                     seen [DEPTH+1];

  // The result register is free when it is empty or its content leaves now.
  assign out_free   = !res_valid || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign item_xfer  = item.valid && item.ready;
  assign full       = count == CW'(DEPTH);

  assign result.valid     = res_valid;
  assign result.out_value = res_value;
  assign result.status    = res_status;
  assign result.last      = res_last;

  // Cell chain. Cell 0 has no left neighbor and the last cell no right one;
  // those inputs never reach an occupied cell, so they are tied to harmless values.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_v;
    logic signed [DATA_W-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = item.new_value;
    end else begin : g_mid_prev
      assign prev_v = values[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = values[0];
    end else begin : g_mid_next
      assign next_v = values[i+1];
    end
    slic_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .new_value  (item.new_value),
      .head_value (values[0]),
      .prev_value (prev_v),
      .next_value (next_v),
      .seen_in    (seen[i]),
      .value      (values[i]),
      .seen_out   (seen[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      left      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      left  <= left_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_value  <= ld_value;
      res_status <= ld_status;
      res_last   <= ld_last;
    end
  end

  // Next state, chain command and result load.
  always_comb begin
    state_next  = state;
    count_next  = count;
    left_next   = left;
    ctrl.op     = CELL_HOLD;
    ctrl.sorted = func_t'(item.func) == FUNC_INSERT;
    load        = 1'b0;
    ld_value    = '0;
    ld_status   = ST_OK;
    ld_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (item_xfer) begin
          unique case (func_t'(item.func))
            FUNC_APPEND, FUNC_INSERT: begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                ctrl.op    = CELL_INSERT;
                count_next = count + CW'(1);
              end
            end
            FUNC_DUMP: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next = S_DUMP;
                left_next  = count;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        // Emit the head and rotate the chain by one on every free slot.
        if (out_free) begin
          load      = 1'b1;
          ld_value  = values[0];
          ld_status = ST_ELEM;
          ld_last   = left == CW'(1);
          ctrl.op   = CELL_ROTATE;
          left_next = left - CW'(1);
          if (left == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/slic_chk.sv]
// Port checker for the sorted list core, bound to the top level.
`default_nettype none
`include "sorted_list_insert_core_assert.svh"
module slic_chk
  import slic_pkg::*;
(
  input wire                      clk,
  input wire                      rst,
  input wire                      item_valid,
  input wire                      item_ready,
  input wire                      result_valid,
  input wire                      result_ready,
  input wire [DATA_W-1:0]         result_out_value,
  input wire [STATUS_W-1:0]       result_status,
  input wire                      result_last
);
  `SLIC_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
  `SLIC_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(result_out_value) && $stable(result_status) && $stable(result_last))
  `SLIC_ASSERT_NOW(a_no_accept_on_stall, item_valid && item_ready, !result_valid || result_ready)
  `SLIC_ASSERT_NOW(a_dump_blocks_input, result_valid && !result_last, !item_ready)
endmodule

bind sorted_list_insert_core slic_chk u_slic_chk (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_out_value (result.out_value),
  .result_status    (result.status),
  .result_last      (result.last)
);
`default_nettype wire
